// File: rtl/gpg_pkg.sv
// Shared types and constants for the gauge pulse generator.
package gpg_pkg;

  localparam int CNT_W       = 16;
  localparam int VAL_W       = 16;
  localparam int DIV_W       = 18;
  localparam int DCNT_W      = $clog2(DIV_W + 1);
  localparam int A_W         = 9;
  localparam int B_W         = 8;
  localparam int Q_W         = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 8;

  localparam logic [CNT_W-1:0] PERIOD_OFF = '1;

  localparam int RPM_BASE = 960;
  localparam int RPM_STEP = 250;
  localparam int SPD_BASE = 1452;
  localparam int SPD_STEP = 5;
  localparam int SPD_MAX  = 255;

  // n / step == (n * ceil(2^RCP_SHIFT / step)) >> RCP_SHIFT for any DIV_W-bit n
  localparam int               RCP_W     = 24;
  localparam int               RCP_SHIFT = 26;
  localparam logic [RCP_W-1:0] RPM_RCP   = RCP_W'(268436);
  localparam logic [RCP_W-1:0] SPD_RCP   = RCP_W'(13421773);

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_TACH  = 2'd1,
    OP_SET_SPEED = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_NOP,
    CMD_TACH_OFF,
    CMD_SPEED_OFF,
    CMD_TACH_SET,
    CMD_SPEED_SET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_FIN
  } back_state_t;

  typedef enum logic {
    PH_Q0,
    PH_Q1
  } div_phase_t;

endpackage

// File: rtl/gpg_front.sv
// Input side: accepts transactions and turns them into queued commands.
module gpg_front
  import gpg_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_USER_W-1:0] in_tuser,  // [1:0] opcode
  input  logic [IN_DATA_W-1:0] in_tdata,  // [15:0] value
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic [VAL_W-1:0] val;
  logic [VAL_W-1:0] spd_sat;

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;
  assign val       = in_tdata[VAL_W-1:0];
  assign spd_sat   = (val > VAL_W'(SPD_MAX)) ? VAL_W'(SPD_MAX) : val;

  always_comb begin
    q_cmd.kind  = CMD_NOP;
    q_cmd.value = '0;
    unique case (opcode_t'(in_tuser))
      OP_TICK: begin
        q_cmd.kind = CMD_TICK;
      end
      OP_SET_TACH: begin
        if (val == '0) begin
          q_cmd.kind = CMD_TACH_OFF;
        end else begin
          // small nonzero rpm is lifted to one full step
          q_cmd.kind  = CMD_TACH_SET;
          q_cmd.value = (val < VAL_W'(RPM_STEP)) ? VAL_W'(RPM_STEP) : val;
        end
      end
      OP_SET_SPEED: begin
        if (spd_sat == '0) begin
          q_cmd.kind = CMD_SPEED_OFF;
        end else begin
          q_cmd.kind  = CMD_SPEED_SET;
          q_cmd.value = (spd_sat < VAL_W'(SPD_STEP)) ? VAL_W'(SPD_STEP) : spd_sat;
        end
      end
      default: begin
        q_cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

// File: rtl/gpg_queue.sv
// Short command FIFO between the front and back ends.
module gpg_queue
  import gpg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/gpg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module gpg_div
  import gpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-1:0]   dvs_r;
  logic [DIV_W:0]     shifted;
  logic [DIV_W:0]     trial;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      // top bit of trial set means the subtract borrowed
      if (!trial[DIV_W]) begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/gpg_back.sv
// Execution side: pulse counters, period computation sequencer, result register.
module gpg_back
  import gpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_stat_t               q_stat,
  input  cmd_t                  q_head,
  output logic                  q_pop,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  back_state_t           state_r, state_nxt;
  div_phase_t            phase_r, phase_nxt;
  logic                  tgt_speed_r;
  logic [VAL_W-1:0]      val_r;
  logic [A_W-1:0]        a_r;
  logic [B_W-1:0]        b_r;
  logic [Q_W-1:0]        q0_r;
  logic [Q_W-1:0]        q1_r;
  logic [DIV_W-1:0]      sum_r;
  logic [CNT_W-1:0]      tach_period_r;
  logic [CNT_W-1:0]      speed_period_r;
  logic [CNT_W-1:0]      tach_cnt_r;
  logic [CNT_W-1:0]      speed_cnt_r;
  logic                  tach_pin_r;
  logic                  speed_pin_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  out_free;
  logic                  head_is_set;
  logic                  load_cmd;
  logic                  exec_item;
  logic                  emit;
  logic                  store_split;
  logic                  store_rem;
  logic                  store_div;
  logic                  store_sum;
  logic                  write_period;

  logic [DIV_W-1:0]      base_sel;
  logic [DIV_W-1:0]      step_sel;
  logic [B_W-1:0]        step_minus_b;
  logic [Q_W+B_W-1:0]    prod1;
  logic [Q_W+B_W-1:0]    prod0;
  logic [DIV_W-1:0]      sum_nxt;

  logic [RCP_W-1:0]       rcp_sel;
  logic [DIV_W-1:0]       rcp_in;
  logic [DIV_W+RCP_W-1:0] rcp_prod;
  logic [Q_W-1:0]         rcp_quot;
  logic [VAL_W-1:0]       a_step;
  logic [VAL_W-1:0]       rem_full;

  logic                  do_tick;
  logic [CNT_W-1:0]      tach_cnt_nxt;
  logic [CNT_W-1:0]      speed_cnt_nxt;
  logic                  tach_pin_nxt;
  logic                  speed_pin_nxt;

  assign out_free    = !out_valid_r || out_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign head_is_set = (q_head.kind == CMD_TACH_SET) || (q_head.kind == CMD_SPEED_SET);

  // ---------------- datapath ----------------
  assign base_sel     = tgt_speed_r ? DIV_W'(SPD_BASE) : DIV_W'(RPM_BASE);
  assign step_sel     = tgt_speed_r ? DIV_W'(SPD_STEP) : DIV_W'(RPM_STEP);
  assign step_minus_b = step_sel[B_W-1:0] - b_r;
  assign prod1        = {{B_W{1'b0}}, q1_r} * {{Q_W{1'b0}}, b_r};
  assign prod0        = {{B_W{1'b0}}, q0_r} * {{Q_W{1'b0}}, step_minus_b};
  // interpolated sum is at most base * step, which fits DIV_W bits
  assign sum_nxt      = prod1[DIV_W-1:0] + prod0[DIV_W-1:0];

  // division by step: value in the split cycle, weighted sum in the final cycle
  assign rcp_sel  = tgt_speed_r ? SPD_RCP : RPM_RCP;
  assign rcp_in   = (state_r == ST_FIN) ? sum_r : DIV_W'(val_r);
  assign rcp_prod = {{RCP_W{1'b0}}, rcp_in} * {{DIV_W{1'b0}}, rcp_sel};
  assign rcp_quot = rcp_prod[RCP_SHIFT +: Q_W];
  assign a_step   = VAL_W'(a_r) * VAL_W'(step_sel[B_W-1:0]);
  assign rem_full = val_r - a_step;

  assign do_tick = exec_item && (q_head.kind == CMD_TICK);

  always_comb begin
    tach_cnt_nxt  = tach_cnt_r;
    speed_cnt_nxt = speed_cnt_r;
    tach_pin_nxt  = tach_pin_r;
    speed_pin_nxt = speed_pin_r;
    if (do_tick) begin
      // reload on zero, then count down; a disabled output never toggles
      tach_cnt_nxt  = ((tach_cnt_r == '0) ? tach_period_r : tach_cnt_r) - 1'b1;
      speed_cnt_nxt = ((speed_cnt_r == '0) ? speed_period_r : speed_cnt_r) - 1'b1;
      if ((tach_cnt_r == '0) && (tach_period_r != PERIOD_OFF)) begin
        tach_pin_nxt = !tach_pin_r;
      end
      if ((speed_cnt_r == '0) && (speed_period_r != PERIOD_OFF)) begin
        speed_pin_nxt = !speed_pin_r;
      end
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty && head_is_set) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (phase_r == PH_Q1) ? ST_MUL : ST_DIV_GO;
        end
      end
      ST_MUL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    q_pop            = 1'b0;
    load_cmd         = 1'b0;
    exec_item        = 1'b0;
    emit             = 1'b0;
    store_split      = 1'b0;
    store_rem        = 1'b0;
    store_div        = 1'b0;
    store_sum        = 1'b0;
    write_period     = 1'b0;
    phase_nxt        = phase_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          if (head_is_set) begin
            q_pop     = 1'b1;
            load_cmd  = 1'b1;
            phase_nxt = PH_Q0;
          end else if (out_free) begin
            q_pop     = 1'b1;
            exec_item = 1'b1;
            emit      = 1'b1;
          end
        end
      end
      ST_SPLIT: begin
        store_split = 1'b1;
      end
      ST_DIV_GO: begin
        div_req.start    = 1'b1;
        store_rem        = 1'b1;
        div_req.dividend = base_sel;
        if (phase_r == PH_Q1) begin
          div_req.divisor = DIV_W'(a_r) + 1'b1;
        end else begin
          div_req.divisor = DIV_W'(a_r);
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          store_div = 1'b1;
          if (phase_r == PH_Q0) begin
            phase_nxt = PH_Q1;
          end
        end
      end
      ST_MUL: begin
        store_sum = 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          write_period = 1'b1;
          emit         = 1'b1;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      val_r <= q_head.value;
    end
    if (store_split) begin
      a_r <= rcp_quot[A_W-1:0];
    end
    if (store_rem) begin
      b_r <= rem_full[B_W-1:0];
    end
    if (store_div) begin
      if (phase_r == PH_Q0) begin
        q0_r <= div_rsp.quot[Q_W-1:0];
      end else begin
        q1_r <= div_rsp.quot[Q_W-1:0];
      end
    end
    if (store_sum) begin
      sum_r <= sum_nxt;
    end
    if (emit) begin
      out_data_r <= {{(OUT_DATA_W-2){1'b0}}, speed_pin_nxt, tach_pin_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      phase_r        <= PH_Q0;
      tgt_speed_r    <= 1'b0;
      tach_period_r  <= PERIOD_OFF;
      speed_period_r <= PERIOD_OFF;
      tach_cnt_r     <= '0;
      speed_cnt_r    <= '0;
      tach_pin_r     <= 1'b0;
      speed_pin_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tach_cnt_r  <= tach_cnt_nxt;
      speed_cnt_r <= speed_cnt_nxt;
      tach_pin_r  <= tach_pin_nxt;
      speed_pin_r <= speed_pin_nxt;
      if (load_cmd) begin
        tgt_speed_r <= (q_head.kind == CMD_SPEED_SET);
      end
      if (exec_item && (q_head.kind == CMD_TACH_OFF)) begin
        tach_period_r <= PERIOD_OFF;
      end
      if (exec_item && (q_head.kind == CMD_SPEED_OFF)) begin
        speed_period_r <= PERIOD_OFF;
      end
      if (write_period) begin
        if (tgt_speed_r) begin
          speed_period_r <= CNT_W'(rcp_quot);
        end else begin
          tach_period_r <= CNT_W'(rcp_quot);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/gauge_pulse_generator.sv
// Two-channel gauge pulse generator (tachometer and speedometer), top level.
// Every input transaction yields one result carrying both pin levels after it.
// Tick, disable and no-op transactions pass at one per cycle while results are
// accepted and no set runs, through the command queue and the result register.
// A set transaction holds the back end through an entry state, a split of the
// value by the step with a reciprocal multiply, base/a and base/(a+1) back to
// back on one shared 18-bit radix-2 divider, the weighted sum, and the final
// reciprocal multiply by 1/step that also issues the result.
// A two-entry command queue takes up to two more items while a set runs.
module gauge_pulse_generator
  import gpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] opcode
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] tach_level, [1] speed_level, rest zero
);

  q_stat_t  q_stat;
  logic     q_push;
  cmd_t     q_cmd;
  logic     q_pop;
  cmd_t     q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  gpg_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  gpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  gpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/sv/gauge_pulse_generator_tb.sv
// Self-checking stream testbench for the gauge pulse generator, with a pin-level scoreboard.
module gauge_pulse_generator_tb;
  import gpg_pkg::*;

  localparam int RANDOM_ITEMS = 860;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int END_WAIT     = 120;

  // Tracks both gauge channels (index 0 tach, 1 speed) and the pin levels they produce.
  class pin_level_scoreboard;
    logic [CNT_W-1:0] period [2];
    logic [CNT_W-1:0] count [2];
    logic [1:0]       pins;
    logic [1:0]       expected_levels [$];
    int               errors;

    function new();
      period[0] = PERIOD_OFF;
      period[1] = PERIOD_OFF;
      count[0]  = '0;
      count[1]  = '0;
      pins      = '0;
      errors    = 0;
    endfunction

    // Interpolated half-period between base/a and base/(a+1); v >= step_sz.
    function logic [CNT_W-1:0] half_period(int unsigned v, int unsigned base,
                                           int unsigned step_sz);
      int unsigned a;
      int unsigned b;
      int unsigned r;
      a = v / step_sz;
      b = v % step_sz;
      r = ((base / (a + 1)) * b + (base / a) * (step_sz - b)) / step_sz;
      return r[CNT_W-1:0];
    endfunction

    function void note_item(opcode_t op, logic [VAL_W-1:0] v);
      int unsigned x;
      x = v;
      case (op)
        OP_TICK: begin
          for (int ch = 0; ch < 2; ch++) begin
            if (count[ch] == '0) begin
              if (period[ch] != PERIOD_OFF) pins[ch] = ~pins[ch];
              count[ch] = period[ch];
            end
            count[ch] = count[ch] - 1'b1;
          end
        end
        OP_SET_TACH: begin
          if (x == 0) begin
            period[0] = PERIOD_OFF;
          end else begin
            if (x < RPM_STEP) x = RPM_STEP;
            period[0] = half_period(x, RPM_BASE, RPM_STEP);
          end
        end
        OP_SET_SPEED: begin
          if (x > SPD_MAX) x = SPD_MAX;
          if (x == 0) begin
            period[1] = PERIOD_OFF;
          end else begin
            if (x < SPD_STEP) x = SPD_STEP;
            period[1] = half_period(x, SPD_BASE, SPD_STEP);
          end
        end
        default: ;
      endcase
      expected_levels.push_back(pins);
    endfunction

    function void check_levels(logic [OUT_DATA_W-1:0] d);
      logic [1:0] want;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, d);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      if (d[0] !== want[0]) begin
        $display("%0t: tach_level expected %b actual %b", $time, want[0], d[0]);
        errors++;
      end
      if (d[1] !== want[1]) begin
        $display("%0t: speed_level expected %b actual %b", $time, want[1], d[1]);
        errors++;
      end
      if (d[OUT_DATA_W-1:2] !== '0) begin
        $display("%0t: padding expected 0 actual %b", $time, d[OUT_DATA_W-1:2]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [1:0] opcode
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [0] tach_level, [1] speed_level, rest zero

  pin_level_scoreboard sb;
  int idle_pct = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  gauge_pulse_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  task automatic send_item(opcode_t op, logic [VAL_W-1:0] v);
    int n;
    if ($urandom_range(0, 99) < idle_pct) begin
      n = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      in_tdata <= VAL_W'($urandom);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= v;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(op, v);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_rpm();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VAL_W'($urandom_range(1, RPM_STEP - 1));
      2:       return VAL_W'($urandom_range(RPM_STEP, 2000));
      3, 4:    return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(8000, 65535));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_speed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VAL_W'($urandom_range(1, SPD_STEP - 1));
      2:       return VAL_W'($urandom_range(SPD_STEP, 60));
      3:       return VAL_W'($urandom_range(SPD_MAX + 1, 65535));
      default: return VAL_W'($urandom_range(100, SPD_MAX));
    endcase
  endfunction

  // A zero set is always followed by a nonzero one, so no channel reloads while
  // disabled here; that would freeze it for a full counter wrap.
  task automatic random_item();
    int r;
    logic [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send_item(OP_TICK, VAL_W'($urandom));
    end else if (r < 88) begin
      v = rand_rpm();
      send_item(OP_SET_TACH, v);
      if (v == '0) send_item(OP_SET_TACH, VAL_W'($urandom_range(1, 65535)));
    end else if (r < 96) begin
      v = rand_speed();
      send_item(OP_SET_SPEED, v);
      if (v == '0) send_item(OP_SET_SPEED, VAL_W'($urandom_range(1, 300)));
    end else begin
      send_item(OP_NONE, VAL_W'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_levels(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_side
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long back-pressure: input side keeps offering until the block stalls
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 399) < idle_pct) begin
        n = $urandom_range(1, 19);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: periods are set before the first tick so both counters reload
    // from real half-periods, not from the disabled value.
    idle_pct = 20;
    send_item(OP_NONE, 16'hFFFF);
    send_item(OP_SET_TACH, 16'd0);
    send_item(OP_SET_TACH, 16'd1);
    send_item(OP_SET_TACH, 16'd249);
    send_item(OP_SET_TACH, 16'd250);
    send_item(OP_SET_TACH, 16'd251);
    send_item(OP_SET_TACH, 16'hFFFF);
    send_item(OP_SET_SPEED, 16'd0);
    send_item(OP_SET_SPEED, 16'd1);
    send_item(OP_SET_SPEED, 16'd4);
    send_item(OP_SET_SPEED, 16'd5);
    send_item(OP_SET_SPEED, 16'd6);
    send_item(OP_SET_SPEED, 16'd256);
    send_item(OP_SET_SPEED, 16'hFFFF);
    send_item(OP_SET_SPEED, 16'd255);
    send_item(OP_NONE, 16'h0000);
    for (int i = 0; i < 9; i++) send_item(OP_TICK, (i % 2) ? 16'hFFFF : 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 8;
          default: idle_pct = 35;
        endcase
      end
      if (i == 300) hold_req = 1'b1;
      if (i == 600) wait_results();
      random_item();
    end
    wait_results();

    // Disabled outputs: pins hold while the counters keep running; a counter
    // that reaches zero now reloads all ones, and later sets wait for the wrap.
    idle_pct = 0;
    send_item(OP_SET_TACH, 16'd0);
    send_item(OP_SET_SPEED, 16'd0);
    for (int i = 0; i < 40; i++) send_item(OP_TICK, VAL_W'($urandom));
    send_item(OP_SET_TACH, 16'hFFFF);
    send_item(OP_SET_SPEED, 16'd255);
    for (int i = 0; i < 20; i++) send_item(OP_TICK, VAL_W'($urandom));

    wait_results();
    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
